// ===== rtl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants of the streaming gaussian blur core.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_RADIUS   = 4;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;

  localparam int SIDE_MAX  = 2 * MAX_RADIUS + 1;
  localparam int NUM_W     = SIDE_MAX * SIDE_MAX;
  localparam int ROW_WORDS = MAX_WIDTH * MAX_CHANNELS;
  localparam int LINE_DEPTH = SIDE_MAX * ROW_WORDS;

  localparam int LADDR_W = $clog2(LINE_DEPTH);
  localparam int WIDX_W  = $clog2(NUM_W);
  localparam int TAP_W   = $clog2(SIDE_MAX + 1);
  localparam int ROWM_W  = $clog2(SIDE_MAX);

  localparam int SAMPLE_W = 8;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W    = PROD_W + $clog2(SIDE_MAX);
  localparam int ACC_W    = PROD_W + $clog2(NUM_W);

  localparam int COL_W = 10;
  localparam int ROW_W = 16;
  localparam int CH_W  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } st_e;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic shift;
    logic mul;
  } cell_ctrl_t;

endpackage

// ===== rtl/gbs_if.sv =====
// ----------------------------------------------------------------------------
// gbs_in_if / gbs_out_if
// Valid/ready channels of the blur core: command words in, result words out.
// ----------------------------------------------------------------------------
interface gbs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [6:0]  weight_index;
  logic [15:0] weight_value;
  logic [7:0]  sample;

  modport source (output valid, cmd, weight_index, weight_value, sample, input ready);
  modport sink   (input valid, cmd, weight_index, weight_value, sample, output ready);
endinterface

interface gbs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blurred;
  logic [15:0] out_row;
  logic [9:0]  out_col;
  logic [1:0]  out_channel;
  logic        frame_end;

  modport source (output valid, blurred, out_row, out_col, out_channel, frame_end,
                  input ready);
  modport sink   (input valid, blurred, out_row, out_col, out_channel, frame_end,
                  output ready);
endinterface

// ===== rtl/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// gbs_ram
// Generic one-write one-read ram with registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gbs_cell.sv =====
// ----------------------------------------------------------------------------
// gbs_cell
// One tap of the window row: holds a sample and weight, shifts them to its
// neighbor, keeps a registered product and a registered running row sum that
// moves one cell further every cycle.
// ----------------------------------------------------------------------------
module gbs_cell import gbs_pkg::*; (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic                active_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic [SUM_W-1:0]    sum_i,
  output logic [SAMPLE_W-1:0] sample_o,
  output logic [WEIGHT_W-1:0] weight_o,
  output logic [SUM_W-1:0]    sum_o
);

  logic [SAMPLE_W-1:0] sample_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SUM_W-1:0]    sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sample_q <= sample_i;
      weight_q <= weight_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= active_i ? (PROD_W'(sample_q) * PROD_W'(weight_q)) : '0;
    end
    sum_q <= sum_i + SUM_W'(prod_q);
  end

  assign sample_o = sample_q;
  assign weight_o = weight_q;
  assign sum_o    = sum_q;

endmodule

// ===== rtl/gaussian_blur_stream_core.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_stream_core
// Streaming square gaussian blur over interleaved 8-bit image components.
//
// in_i carries command words: cmd 0 loads one kernel weight (unsigned Q0.16,
// row-major over a side of 2*radius+1), cmd 1 delivers one pixel component
// in raster, channel-interleaved order. out_o carries one word for every
// interior component: the weighted sum truncated and saturated at 255, its
// row, column and channel, and frame_end on the last one of the frame.
// Registers (width, height, channels, radius) are written over cfg_*_i; the
// user must do so only while the core is idle: the core does not enforce it.
// A weight word and a border component need no window pass. An interior
// component holds the core for one: the window is read one tap per
// cycle from the line store ram, taps shift through a row of cells and
// each finished row sum ripples through the cells' sum registers into the
// accumulator.
// The result sits in an output register; the next word is taken while it
// waits, and a further result holds the core until the receiver takes it.
// Reset clears the weights to zero, the position counters and the
// registers (width 1024, height 1, channels 1, radius 1); no clearing pass.
// ----------------------------------------------------------------------------
module gaussian_blur_stream_core import gbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gbs_in_if.sink                in_i,
  gbs_out_if.source             out_o
);

  // registers
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [2:0]  chans_q;
  logic [2:0]  radius_q;

  logic [10:0] eff_w;
  logic [15:0] eff_h;
  logic [2:0]  eff_nc;
  logic [2:0]  eff_rad;
  logic [TAP_W-1:0] side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 16'd1;
      chans_q  <= 3'd1;
      radius_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:    width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT:   height_q <= cfg_data_i[15:0];
        CFG_CHANNELS: chans_q  <= cfg_data_i[2:0];
        CFG_RADIUS:   radius_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w   = (width_q == '0) ? 11'd1 :
              (int'(width_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_q;
    eff_h   = (height_q == '0) ? 16'd1 : height_q;
    eff_nc  = (chans_q == '0) ? 3'd1 :
              (int'(chans_q) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : chans_q;
    eff_rad = (int'(radius_q) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_q;
    side    = TAP_W'(2 * int'(eff_rad) + 1);
  end

  // position counters
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CH_W-1:0]   ch_q;
  logic [ROWM_W-1:0] rowm_q;

  st_e  state_q, state_d;
  logic in_ready;
  logic in_acc;
  logic smp_acc;
  logic produce;

  assign in_ready    = (state_q == ST_IDLE);
  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid && in_ready;
  assign smp_acc     = in_acc && (in_i.cmd == CMD_SAMPLE);
  assign produce     = (int'(row_q) >= 2 * int'(eff_rad)) &&
                       (int'(col_q) >= 2 * int'(eff_rad));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ch_q   <= '0;
      rowm_q <= '0;
    end else if (smp_acc) begin
      if (({1'b0, ch_q} + 3'd1) >= eff_nc) begin
        ch_q <= '0;
        if (({1'b0, col_q} + 11'd1) >= eff_w) begin
          col_q <= '0;
          if (({1'b0, row_q} + 17'd1) >= {1'b0, eff_h}) begin
            row_q  <= '0;
            rowm_q <= '0;
          end else begin
            row_q  <= row_q + 1'b1;
            rowm_q <= (int'(rowm_q) == SIDE_MAX - 1) ? '0 : rowm_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  // item latched for the window pass
  logic [COL_W-1:0]  it_col_q;
  logic [ROW_W-1:0]  it_row_q;
  logic [CH_W-1:0]   it_ch_q;
  logic [ROWM_W-1:0] it_rowm_q;
  logic              it_end_q;

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      it_col_q  <= col_q;
      it_row_q  <= row_q;
      it_ch_q   <= ch_q;
      it_rowm_q <= rowm_q;
      it_end_q  <= ({1'b0, row_q} == {1'b0, eff_h} - 17'd1) &&
                   ({1'b0, col_q} == eff_w - 11'd1) &&
                   ({1'b0, ch_q} == eff_nc - 3'd1);
    end
  end

  // tap sequencer
  logic [TAP_W-1:0]  ti_q, tj_q;
  logic [WIDX_W-1:0] widx_q;
  logic              issue;
  logic              issue_last;
  logic              row_last;

  assign row_last   = (tj_q == side - 1'b1);
  assign issue_last = row_last && (ti_q == side - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ti_q   <= '0;
      tj_q   <= '0;
      widx_q <= '0;
    end else if (smp_acc) begin
      ti_q   <= '0;
      tj_q   <= '0;
      widx_q <= '0;
    end else if (issue) begin
      widx_q <= widx_q + 1'b1;
      if (row_last) begin
        tj_q <= '0;
        ti_q <= ti_q + 1'b1;
      end else begin
        tj_q <= tj_q + 1'b1;
      end
    end
  end

  // line store addresses
  logic [LADDR_W-1:0] waddr, raddr;
  logic [ROWM_W-1:0]  rd_rowm;
  logic [COL_W-1:0]   rd_col;

  always_comb begin
    int t;
    t = int'(it_rowm_q) + int'(ti_q) - 2 * int'(eff_rad);
    if (t < 0) begin
      t = t + SIDE_MAX;
    end else if (t >= SIDE_MAX) begin
      t = t - SIDE_MAX;
    end
    rd_rowm = ROWM_W'(t);
    rd_col  = COL_W'(int'(it_col_q) - 2 * int'(eff_rad) + int'(tj_q));
    waddr   = LADDR_W'(int'(rowm_q) * ROW_WORDS + int'(col_q) * MAX_CHANNELS
                       + int'(ch_q));
    raddr   = LADDR_W'(int'(rd_rowm) * ROW_WORDS + int'(rd_col) * MAX_CHANNELS
                       + int'(it_ch_q));
  end

  logic [SAMPLE_W-1:0] line_rdata;

  gbs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (smp_acc),
    .waddr_i (waddr),
    .wdata_i (in_i.sample),
    .raddr_i (raddr),
    .rdata_o (line_rdata)
  );

  // kernel weights, zero until loaded
  logic                w_we;
  logic [NUM_W-1:0]    wvalid_q;
  logic                wv_q;
  logic [WEIGHT_W-1:0] w_rdata;

  assign w_we = in_acc && (in_i.cmd == CMD_WEIGHT) && (int'(in_i.weight_index) < NUM_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      wv_q     <= 1'b0;
    end else begin
      if (w_we) begin
        wvalid_q[WIDX_W'(in_i.weight_index)] <= 1'b1;
      end
      wv_q <= wvalid_q[widx_q];
    end
  end

  gbs_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (NUM_W)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (WIDX_W'(in_i.weight_index)),
    .wdata_i (in_i.weight_value),
    .raddr_i (widx_q),
    .rdata_o (w_rdata)
  );

  // pipeline flags
  logic                rd_v_q, rd_last_q, cell_last_q, prod_v_q;
  logic [SIDE_MAX-1:0] sum_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      cell_last_q <= 1'b0;
      prod_v_q    <= 1'b0;
      sum_v_q     <= '0;
    end else begin
      rd_v_q      <= issue;
      rd_last_q   <= issue && row_last;
      cell_last_q <= rd_v_q && rd_last_q;
      prod_v_q    <= cell_last_q;
      sum_v_q     <= {sum_v_q[SIDE_MAX-2:0], prod_v_q};
    end
  end

  // row of cells
  cell_ctrl_t          cell_ctrl;
  logic [SAMPLE_W-1:0] c_smp [SIDE_MAX+1];
  logic [WEIGHT_W-1:0] c_wgt [SIDE_MAX+1];
  logic [SUM_W-1:0]    c_sum [SIDE_MAX+1];

  assign cell_ctrl.shift = rd_v_q;
  assign cell_ctrl.mul   = cell_last_q;
  assign c_smp[0] = line_rdata;
  assign c_wgt[0] = wv_q ? w_rdata : '0;
  assign c_sum[0] = '0;

  for (genvar k = 0; k < SIDE_MAX; k++) begin : g_cell
    gbs_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .active_i (k < int'(side)),
      .sample_i (c_smp[k]),
      .weight_i (c_wgt[k]),
      .sum_i    (c_sum[k]),
      .sample_o (c_smp[k+1]),
      .weight_o (c_wgt[k+1]),
      .sum_o    (c_sum[k+1])
    );
  end

  logic [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      acc_q <= '0;
    end else if (sum_v_q[SIDE_MAX-1]) begin
      acc_q <= acc_q + ACC_W'(c_sum[SIDE_MAX]);
    end
  end

  // output register
  logic              out_v_q;
  logic [7:0]        blur_q;
  logic [ROW_W-1:0]  orow_q;
  logic [COL_W-1:0]  ocol_q;
  logic [CH_W-1:0]   och_q;
  logic              oend_q;
  logic              load_out;
  logic [ACC_W-17:0] scaled;

  assign scaled = acc_q[ACC_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      blur_q <= (scaled > (ACC_W-16)'(255)) ? 8'd255 : scaled[7:0];
      orow_q <= it_row_q - ROW_W'(eff_rad);
      ocol_q <= it_col_q - COL_W'(eff_rad);
      och_q  <= it_ch_q;
      oend_q <= it_end_q;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.blurred     = blur_q;
  assign out_o.out_row     = orow_q;
  assign out_o.out_col     = ocol_q;
  assign out_o.out_channel = och_q;
  assign out_o.frame_end   = oend_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc && produce) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !cell_last_q && !prod_v_q && (sum_v_q == '0)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_v_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // checks
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (int'(widx_q) < int'(side) * int'(side)))
    else $error("tap index beyond kernel");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (!rd_v_q && !cell_last_q && !prod_v_q && (sum_v_q == '0)))
    else $error("result taken before window pass drained");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result word outside finish state");

  a_no_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !issue)
    else $error("tap issued while accepting words");

endmodule
